@@ rtl/cpa_pkg.sv @@
package cpa_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int ACC_BITS      = 48;
    localparam int CORDIC_STEPS  = 16;
    localparam int NUM_BASELINES = 3;
    localparam int CW            = 66;

    localparam logic [1:0] REG_AVG_COUNT  = 2'd0;
    localparam logic [1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_ORDER      = 2'd2;

    typedef struct packed {
        logic signed [15:0] vis0_re;
        logic signed [15:0] vis0_im;
        logic signed [15:0] vis1_re;
        logic signed [15:0] vis1_im;
        logic signed [15:0] vis2_re;
        logic signed [15:0] vis2_im;
        logic               last_channel;
        logic [31:0]        time_stamp;
        logic               end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        time_offset;
        logic signed [15:0] closure_phase;
        logic signed [15:0] phase_base0;
        logic signed [15:0] phase_base1;
        logic signed [15:0] phase_base2;
    } out_item_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/closure_phase_averager_top.sv @@
// Closure phase averager for a three-baseline triangle.
// Channels: in (in_valid/in_ready, cpa_pkg::in_item_t), out (out_valid/out_ready,
// cpa_pkg::out_item_t), cfg (cfg_valid/cfg_ready, cfg_index, cfg_data); cfg is
// always ready and must be written only while idle.
// A sample item is accepted, then each of the three baselines is screened in turn
// through the shared squarer, then the item is accumulated before the next accept.
// An end-of-data item with nothing pending passes through the wait state only.
// An item that closes a group (or an end-of-data flush) then runs the shared
// sequencer: normalize each sum one shift per cycle, two complex products on one
// multiplier, and four CORDIC runs of 16 iterations on one shift-add unit, each run
// framed by an initialization state and an end state.
// The result goes to an output register; the next item is accepted while it
// waits for out_ready, but a new result is not started until it is taken.
// Reset clears sums, counters and flags (but sets the at-start flag) and sets avg_count 1, threshold 16384,
// product order 0. A stalled receiver holds the result steady.
module closure_phase_averager_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpa_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cpa_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import cpa_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCRN  = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_NORM  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_CINIT = 4'd6;
    localparam logic [3:0] S_CIT   = 4'd7;
    localparam logic [3:0] S_CEND  = 4'd8;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic [3:0]  state_reg, state_next;
    logic [15:0] avg_count_reg;
    logic [14:0] thr_reg;
    logic        order_reg;

    logic signed [ACC_BITS-1:0] sr_reg [NUM_BASELINES];
    logic signed [ACC_BITS-1:0] si_reg [NUM_BASELINES];
    logic [15:0] gcount_reg;
    logic [31:0] start_reg, gtime_reg;
    logic        seen_reg, atstart_reg;

    in_item_t    item_reg;
    logic [2:0]  keep_reg;
    logic [1:0]  b_reg;
    logic [4:0]  it_reg;
    logic        emit_reg;

    logic signed [15:0] nr_reg [NUM_BASELINES];
    logic signed [15:0] ni_reg [NUM_BASELINES];
    logic [ACC_BITS-1:0] mr_reg, mi_reg;

    logic signed [63:0] pr_reg, pi_reg, qr_reg, qi_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [31:0] cz_reg;
    logic [2:0]  ph_idx_reg;
    logic [15:0] ph_reg [4];

    out_item_t   out_reg;
    logic        out_valid_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // shared squarer for the screen
    logic signed [15:0] scr_re, scr_im;
    logic [31:0] mag2_sum;
    logic [16:0] mre, mim;
    always_comb
    begin
        case (b_reg)
            2'd0:    begin scr_re = item_reg.vis0_re; scr_im = item_reg.vis0_im; end
            2'd1:    begin scr_re = item_reg.vis1_re; scr_im = item_reg.vis1_im; end
            default: begin scr_re = item_reg.vis2_re; scr_im = item_reg.vis2_im; end
        endcase
        mre = scr_re[15] ? 17'(-$signed({scr_re[15], scr_re})) : {1'b0, scr_re};
        mim = scr_im[15] ? 17'(-$signed({scr_im[15], scr_im})) : {1'b0, scr_im};
        mag2_sum = 32'(mre) * 32'(mre) + 32'(mim) * 32'(mim);
    end
    logic [29:0] thr2;
    assign thr2 = 30'(thr_reg) * 30'(thr_reg);

    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] a, input logic signed [15:0] v);
        logic signed [ACC_BITS:0] s;
        begin
            s = {a[ACC_BITS-1], a} + (ACC_BITS+1)'(v);
            if (s > $signed({1'b0, ACC_MAX}))
                return ACC_MAX;
            if (s < $signed({1'b1, ACC_MIN}))
                return ACC_MIN;
            return s[ACC_BITS-1:0];
        end
    endfunction

    // shared multiplier operands for the products
    logic signed [31:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [47:0] mul_p;
    logic signed [15:0] c1, c2;
    assign c1 = order_reg ? ni_reg[1] : -ni_reg[1];
    assign c2 = order_reg ? -ni_reg[2] : ni_reg[2];
    always_comb
    begin
        case (it_reg[2:0])
            3'd0:    begin mul_a = 32'(nr_reg[0]); mul_b = nr_reg[1]; end
            3'd1:    begin mul_a = 32'(ni_reg[0]); mul_b = c1; end
            3'd2:    begin mul_a = 32'(nr_reg[0]); mul_b = c1; end
            3'd3:    begin mul_a = 32'(ni_reg[0]); mul_b = nr_reg[1]; end
            3'd4:    begin mul_a = 32'(pr_reg); mul_b = nr_reg[2]; end
            3'd5:    begin mul_a = 32'(pi_reg); mul_b = c2; end
            3'd6:    begin mul_a = 32'(pr_reg); mul_b = c2; end
            default: begin mul_a = 32'(pi_reg); mul_b = nr_reg[2]; end
        endcase
        mul_p = 48'(mul_a) * 48'(mul_b);
    end

    logic [ACC_BITS-1:0] nmax;
    assign nmax = (mr_reg > mi_reg) ? mr_reg : mi_reg;
    logic signed [ACC_BITS-1:0] cur_r, cur_i;
    assign cur_r = sr_reg[b_reg];
    assign cur_i = si_reg[b_reg];

    logic signed [CW-1:0] dx, dy;
    assign dx = cy_reg >>> it_reg;
    assign dy = cx_reg >>> it_reg;

    logic signed [CW-1:0] src_x, src_y;
    always_comb
    begin
        case (ph_idx_reg)
            3'd0:    begin src_x = CW'(qr_reg); src_y = CW'(qi_reg); end
            3'd1:    begin src_x = CW'(sr_reg[0]); src_y = CW'(si_reg[0]); end
            3'd2:    begin src_x = CW'(sr_reg[1]); src_y = CW'(si_reg[1]); end
            default: begin src_x = CW'(sr_reg[2]); src_y = CW'(si_reg[2]); end
        endcase
    end

    logic gdone;
    assign gdone = item_reg.last_channel && ((gcount_reg + 16'd1) == avg_count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid)
                         state_next = in_data.end_of_data ? S_WAIT : S_SCRN;
            S_SCRN:  if (b_reg == 2'd2) state_next = S_ACC;
            S_ACC:   state_next = gdone ? S_WAIT : S_IDLE;
            S_WAIT:  if (!emit_reg) state_next = S_IDLE;
                     else if (!out_valid_reg) state_next = S_NORM;
            S_NORM:  if (nmax == '0 || (nmax < 16384 && nmax >= 8192))
                         if (b_reg == 2'd2) state_next = S_MUL;
            S_MUL:   if (it_reg == 5'd7) state_next = S_CINIT;
            S_CINIT: state_next = S_CIT;
            S_CIT:   if (it_reg == 5'(CORDIC_STEPS - 1)) state_next = S_CEND;
            S_CEND:  state_next = (ph_idx_reg == 3'd3) ? S_IDLE : S_CINIT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            avg_count_reg <= 16'd1;
            thr_reg       <= 15'd16384;
            order_reg     <= 1'b0;
            for (int b = 0; b < NUM_BASELINES; b++)
            begin
                sr_reg[b] <= '0;
                si_reg[b] <= '0;
            end
            gcount_reg    <= '0;
            start_reg     <= '0;
            gtime_reg     <= '0;
            seen_reg      <= 1'b0;
            atstart_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            b_reg         <= '0;
            it_reg        <= '0;
            emit_reg      <= 1'b0;
            ph_idx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_AVG_COUNT: avg_count_reg <= cfg_data;
                    REG_THRESHOLD: thr_reg       <= cfg_data[14:0];
                    REG_ORDER:     order_reg     <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        item_reg <= in_data;
                        b_reg    <= '0;
                        emit_reg <= in_data.end_of_data &&
                                    (gcount_reg != 16'd0 || !atstart_reg);
                        if (!in_data.end_of_data && atstart_reg)
                        begin
                            if (!seen_reg)
                            begin
                                start_reg <= in_data.time_stamp;
                                seen_reg  <= 1'b1;
                            end
                            if (gcount_reg == 16'd0)
                                gtime_reg <= in_data.time_stamp;
                            atstart_reg <= 1'b0;
                        end
                    end
                S_SCRN:
                begin
                    keep_reg[b_reg] <= (mag2_sum <= 32'(thr2));
                    b_reg <= b_reg + 2'd1;
                end
                S_ACC:
                begin
                    sr_reg[0] <= sat_add(sr_reg[0], keep_reg[0] ? item_reg.vis0_re : 16'sd0);
                    si_reg[0] <= sat_add(si_reg[0], keep_reg[0] ? item_reg.vis0_im : 16'sd0);
                    sr_reg[1] <= sat_add(sr_reg[1], keep_reg[1] ? item_reg.vis1_re : 16'sd0);
                    si_reg[1] <= sat_add(si_reg[1], keep_reg[1] ? item_reg.vis1_im : 16'sd0);
                    sr_reg[2] <= sat_add(sr_reg[2], keep_reg[2] ? item_reg.vis2_re : 16'sd0);
                    si_reg[2] <= sat_add(si_reg[2], keep_reg[2] ? item_reg.vis2_im : 16'sd0);
                    if (item_reg.last_channel)
                    begin
                        atstart_reg <= 1'b1;
                        gcount_reg  <= gcount_reg + 16'd1;
                    end
                    emit_reg <= gdone;
                    b_reg    <= '0;
                end
                S_WAIT:
                begin
                    b_reg  <= '0;
                    mr_reg <= sr_reg[0][ACC_BITS-1] ? ACC_BITS'(-sr_reg[0]) : sr_reg[0];
                    mi_reg <= si_reg[0][ACC_BITS-1] ? ACC_BITS'(-si_reg[0]) : si_reg[0];
                end
                S_NORM:
                begin
                    if (nmax >= 16384)
                    begin
                        mr_reg <= mr_reg >> 1;
                        mi_reg <= mi_reg >> 1;
                    end
                    else if (nmax != '0 && nmax < 8192)
                    begin
                        mr_reg <= mr_reg << 1;
                        mi_reg <= mi_reg << 1;
                    end
                    else
                    begin
                        nr_reg[b_reg] <= cur_r[ACC_BITS-1] ? -$signed(mr_reg[15:0])
                                                           : $signed(mr_reg[15:0]);
                        ni_reg[b_reg] <= cur_i[ACC_BITS-1] ? -$signed(mi_reg[15:0])
                                                           : $signed(mi_reg[15:0]);
                        if (b_reg != 2'd2)
                        begin
                            mr_reg <= sr_reg[b_reg+2'd1][ACC_BITS-1]
                                      ? ACC_BITS'(-sr_reg[b_reg+2'd1]) : sr_reg[b_reg+2'd1];
                            mi_reg <= si_reg[b_reg+2'd1][ACC_BITS-1]
                                      ? ACC_BITS'(-si_reg[b_reg+2'd1]) : si_reg[b_reg+2'd1];
                        end
                        b_reg  <= b_reg + 2'd1;
                        it_reg <= '0;
                    end
                end
                S_MUL:
                begin
                    case (it_reg[2:0])
                        3'd0:    pr_reg <= 64'(mul_p);
                        3'd1:    pr_reg <= pr_reg - 64'(mul_p);
                        3'd2:    pi_reg <= 64'(mul_p);
                        3'd3:    pi_reg <= pi_reg + 64'(mul_p);
                        3'd4:    qr_reg <= 64'(mul_p);
                        3'd5:    qr_reg <= qr_reg - 64'(mul_p);
                        3'd6:    qi_reg <= 64'(mul_p);
                        default: qi_reg <= qi_reg + 64'(mul_p);
                    endcase
                    it_reg     <= it_reg + 5'd1;
                    ph_idx_reg <= '0;
                end
                S_CINIT:
                begin
                    it_reg <= '0;
                    if (src_x < 0)
                    begin
                        cx_reg <= -src_x;
                        cy_reg <= -src_y;
                        cz_reg <= 32'h80000000;
                    end
                    else
                    begin
                        cx_reg <= src_x;
                        cy_reg <= src_y;
                        cz_reg <= '0;
                    end
                end
                S_CIT:
                begin
                    if (cy_reg > 0)
                    begin
                        cx_reg <= cx_reg + dx;
                        cy_reg <= cy_reg - dy;
                        cz_reg <= cz_reg + atan_lut(it_reg);
                    end
                    else
                    begin
                        cx_reg <= cx_reg - dx;
                        cy_reg <= cy_reg + dy;
                        cz_reg <= cz_reg - atan_lut(it_reg);
                    end
                    it_reg <= it_reg + 5'd1;
                end
                S_CEND:
                begin
                    ph_reg[ph_idx_reg[1:0]] <= (src_x == 0 && src_y == 0) ? 16'd0
                                               : 16'((cz_reg + 32'h8000) >> 16);
                    ph_idx_reg <= ph_idx_reg + 3'd1;
                    if (ph_idx_reg == 3'd3)
                    begin
                        out_reg.time_offset   <= gtime_reg - start_reg;
                        out_reg.closure_phase <= ph_reg[0];
                        out_reg.phase_base0   <= ph_reg[1];
                        out_reg.phase_base1   <= ph_reg[2];
                        out_reg.phase_base2   <= (src_x == 0 && src_y == 0) ? 16'd0
                                                 : 16'((cz_reg + 32'h8000) >> 16);
                        out_valid_reg <= 1'b1;
                        for (int b = 0; b < NUM_BASELINES; b++)
                        begin
                            sr_reg[b] <= '0;
                            si_reg[b] <= '0;
                        end
                        gcount_reg  <= '0;
                        atstart_reg <= 1'b1;
                        emit_reg    <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> gcount_reg == 16'd0 && atstart_reg)
        else $error("group not cleared");
    a_norm_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT && emit_reg && out_valid |=> state_reg == S_WAIT)
        else $error("overwrote pending result");

endmodule
